FILE: design/box_overlap_suppression_unit_macros.svh
// Assertion macros for the box overlap suppression unit.
// Included by the checker; no other dependencies.
`ifndef BOX_OVERLAP_SUPPRESSION_UNIT_MACROS_SVH
`define BOX_OVERLAP_SUPPRESSION_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define BOSU_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define BOSU_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/bosu_pkg.sv
// Shared types and constants for the box overlap suppression unit.
// No dependencies.
`timescale 1ns / 1ps

package bosu_pkg;

	localparam logic [15:0] THR_RESET = 16'd29491;
	localparam logic REG_IOU_THRESHOLD = 1'b0;
	localparam int PIPE_DEPTH = 5;
	localparam int DRAIN_W = 3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} bosu_state_t;

	typedef struct packed {
		logic [31:0] area;
		logic [15:0] height;
		logic [15:0] width;
		logic [15:0] top;
		logic [15:0] left;
	} bosu_entry_t;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic commit;
	} bosu_cmd_t;

	typedef struct packed {
		logic out_busy;
	} bosu_status_t;

endpackage

FILE: design/bosu_ctrl.sv
// Controller for the box overlap suppression unit: accept, scan, drain, commit.
// Depends on bosu_pkg.
`timescale 1ns / 1ps

module bosu_ctrl import bosu_pkg::*; #(
	parameter int CW = 7,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bosu_status_t  status,
	input  logic [CW-1:0] scan_len,
	output bosu_cmd_t     cmd,
	output logic [AW-1:0] rd_addr
);

	bosu_state_t state_q, state_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [DRAIN_W-1:0] drain_q, drain_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			drain_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			drain_q <= drain_d;
		end
	end

	assign rd_addr = idx_q[AW-1:0];

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		drain_d = drain_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					idx_d = '0;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_len == '0) begin
					state_d = ST_COMMIT;
				end else begin
					cmd.rd_en = 1'b1;
					if (idx_q == scan_len - CW'(1)) begin
						idx_d = '0;
						drain_d = '0;
						state_d = ST_DRAIN;
					end else begin
						idx_d = idx_q + CW'(1);
					end
				end
			end
			ST_DRAIN: begin
				if (drain_q == DRAIN_W'(PIPE_DEPTH - 1)) begin
					drain_d = '0;
					state_d = ST_COMMIT;
				end else begin
					drain_d = drain_q + DRAIN_W'(1);
				end
			end
			ST_COMMIT: begin
				if (!status.out_busy) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: design/bosu_datapath.sv
// Datapath: kept-box store, overlap test pipeline, counters and result register.
// Depends on bosu_pkg.
`timescale 1ns / 1ps

module bosu_datapath import bosu_pkg::*; #(
	parameter int MAX_KEPT = 64,
	parameter int MAX_BOXES = 1024,
	parameter int CW = 7,
	parameter int AW = 6,
	parameter int PW = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bosu_cmd_t          cmd,
	input  logic [AW-1:0]      rd_addr,
	output bosu_status_t       status,
	output logic [CW-1:0]      scan_len,
	input  logic [15:0]        thr,
	input  logic               first_of_set,
	input  logic signed [15:0] box_left,
	input  logic signed [15:0] box_top,
	input  logic [15:0]        box_width,
	input  logic [15:0]        box_height,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [9:0]         box_index,
	output logic               kept,
	output logic               list_full
);

	function automatic logic [15:0] overlap(logic signed [15:0] a0, logic [15:0] al,
			logic signed [15:0] b0, logic [15:0] bl);
		logic signed [18:0] ae, be, mn, mx, d;
		ae = 19'(a0) + $signed({3'b0, al});
		be = 19'(b0) + $signed({3'b0, bl});
		mn = (ae < be) ? ae : be;
		mx = (a0 > b0) ? 19'(a0) : 19'(b0);
		d = mn - mx;
		return (d > 19'sd0) ? d[15:0] : 16'd0;
	endfunction

	bosu_entry_t mem [MAX_KEPT];

	logic signed [15:0] left_q, top_q;
	logic [15:0] width_q, height_q;
	logic [31:0] area_q;
	logic [CW-1:0] cnt_q, kept_total_q;
	logic [PW-1:0] pos_q, set_position_q;
	logic keep_q;

	bosu_entry_t rd_s1;
	logic [15:0] iw_s2, ih_s2;
	logic [31:0] karea_s2, karea_s3, inter_s3, inter_s4, inter_s5;
	logic [32:0] uni_s4;
	logic [48:0] prod_s5;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic out_valid_q, kept_q, full_q;
	logic [PW-1:0] idx_out_q;
	logic [PW+9:0] idx_ext;
	logic store, suppress;

	assign scan_len = cnt_q;
	assign status.out_busy = out_valid_q && !out_ready;
	assign store = keep_q && (cnt_q < CW'(MAX_KEPT));
	assign suppress = {1'b0, inter_s5, 16'b0} > prod_s5;

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			left_q <= box_left;
			top_q <= box_top;
			width_q <= box_width;
			height_q <= box_height;
			area_q <= box_width * box_height;
		end
	end

	// kept-box store
	always_ff @(posedge clk) begin
		if (cmd.commit && store) begin
			mem[cnt_q[AW-1:0]] <= '{area: area_q, height: height_q, width: width_q,
				top: top_q, left: left_q};
		end
		if (cmd.rd_en) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	// overlap test pipeline
	always_ff @(posedge clk) begin
		iw_s2 <= overlap(left_q, width_q, $signed(rd_s1.left), rd_s1.width);
		ih_s2 <= overlap(top_q, height_q, $signed(rd_s1.top), rd_s1.height);
		karea_s2 <= rd_s1.area;
		inter_s3 <= iw_s2 * ih_s2;
		karea_s3 <= karea_s2;
		uni_s4 <= {1'b0, area_q} + {1'b0, karea_s3} - {1'b0, inter_s3};
		inter_s4 <= inter_s3;
		prod_s5 <= thr * uni_s4;
		inter_s5 <= inter_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_en;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// per-item and per-set counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pos_q <= '0;
			keep_q <= 1'b1;
			kept_total_q <= '0;
			set_position_q <= '0;
		end else begin
			if (cmd.load) begin
				cnt_q <= first_of_set ? '0 : kept_total_q;
				pos_q <= first_of_set ? '0 : set_position_q;
				keep_q <= 1'b1;
			end else if (vld_s5 && suppress) begin
				keep_q <= 1'b0;
			end
			if (cmd.commit) begin
				kept_total_q <= cnt_q + CW'(store);
				set_position_q <= (pos_q == PW'(MAX_BOXES - 1)) ? '0 : pos_q + PW'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			idx_out_q <= pos_q;
			kept_q <= keep_q;
			full_q <= keep_q && !store;
		end
	end

	assign idx_ext = {10'b0, idx_out_q};
	assign out_valid = out_valid_q;
	assign box_index = idx_ext[9:0];
	assign kept = kept_q;
	assign list_full = full_q;

endmodule

FILE: design/box_overlap_suppression_unit.sv
// Greedy non-maximum suppression over score-sorted boxes. Each accepted box is
// tested against every box kept so far in its set, one kept box per cycle
// through a five-stage overlap pipeline fed from the single read port of the
// kept-box store, which holds at most MAX_KEPT boxes of a set. A result
// waiting in the output register does not hold off the next input transfer,
// but the next result is held until it is taken.
// iou_threshold sits at byte address 0 (Q0.16).
// Top level; depends on bosu_pkg, bosu_ctrl, bosu_datapath.
`timescale 1ns / 1ps

module box_overlap_suppression_unit import bosu_pkg::*; #(
	parameter int MAX_KEPT = 64,
	parameter int MAX_BOXES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               first_of_set,
	input  logic signed [15:0] box_left,
	input  logic signed [15:0] box_top,
	input  logic [15:0]        box_width,
	input  logic [15:0]        box_height,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [9:0]         box_index,
	output logic               kept,
	output logic               list_full
);

	localparam int CW = $clog2(MAX_KEPT + 1);
	localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int PW = $clog2(MAX_BOXES);

	logic [15:0] thr_q;
	logic reg_sel;
	bosu_cmd_t cmd;
	bosu_status_t status;
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] scan_len;

	assign pready = 1'b1;
	assign reg_sel = (paddr[2] == REG_IOU_THRESHOLD);
	assign prdata = reg_sel ? {16'b0, thr_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			thr_q <= pwdata[15:0];
		end
	end

	bosu_ctrl #(
		.CW(CW),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status(status),
		.scan_len(scan_len),
		.cmd(cmd),
		.rd_addr(rd_addr)
	);

	bosu_datapath #(
		.MAX_KEPT(MAX_KEPT),
		.MAX_BOXES(MAX_BOXES),
		.CW(CW),
		.AW(AW),
		.PW(PW)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.rd_addr(rd_addr),
		.status(status),
		.scan_len(scan_len),
		.thr(thr_q),
		.first_of_set(first_of_set),
		.box_left(box_left),
		.box_top(box_top),
		.box_width(box_width),
		.box_height(box_height),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.box_index(box_index),
		.kept(kept),
		.list_full(list_full)
	);

endmodule

FILE: design/bosu_checker.sv
// Port-level checks for box_overlap_suppression_unit, bound to the top level.
// Depends on box_overlap_suppression_unit_macros.svh.
`timescale 1ns / 1ps
`include "box_overlap_suppression_unit_macros.svh"

module bosu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [9:0] box_index,
	input logic       kept,
	input logic       list_full
);

	`BOSU_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(box_index) && $stable(kept) && $stable(list_full), "stalled result changed")
	`BOSU_ASSERT_IMP(a_full_kept, clk, arst_n, out_valid && list_full, kept, "list_full without kept")
	`BOSU_ASSERT_NXT(a_one_busy, clk, arst_n, in_valid && in_ready, !in_ready, "second transfer while busy")
	`BOSU_ASSERT_IMP(a_result_busy, clk, arst_n, $rose(out_valid), !$past(in_ready), "result while idle")

endmodule

bind box_overlap_suppression_unit bosu_checker u_bosu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.box_index(box_index),
	.kept(kept),
	.list_full(list_full)
);
